// ----- rtl/core/btp_pkg.sv -----
// ----------------------------------------------------------------------------
// btp_pkg
// Shared types, constants and helper functions for the banding test
// pattern pixel unit.
// ----------------------------------------------------------------------------
package btp_pkg;

    // Frame geometry
    localparam int MAX_DIM   = 4096;
    localparam int CFG_W     = 13;
    localparam int DIM_W     = $clog2(MAX_DIM) + 1;
    localparam int PIX_W     = 12;
    localparam int CHAN_W    = 8;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 2;

    // 6y+3 and 4x+2 sample positions
    localparam int TY_W      = PIX_W + 3;
    localparam int TX_W      = PIX_W + 2;

    // Ramp quotient: 10 bits plus a saturation flag, two bits per stage
    localparam int QUO_W      = 10;
    localparam int DIV_STAGES = QUO_W / 2;
    localparam int NUM_W      = TX_W + 10;
    localparam int LVL_W      = 19;

    localparam logic [CHAN_W-1:0] DARK_LEVEL = 8'd20;
    localparam logic [CHAN_W-1:0] LEVEL_MAX  = 8'd255;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Column colour codes, left to right
    localparam logic [COL_W-1:0] COL_GRAY  = 2'd0;
    localparam logic [COL_W-1:0] COL_RED   = 2'd1;
    localparam logic [COL_W-1:0] COL_GREEN = 2'd2;
    localparam logic [COL_W-1:0] COL_BLUE  = 2'd3;

    // One divider pipeline stage
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [DIM_W-1:0] w;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             dark;
        logic             sat;
    } div_t;

    // Zero counts as one, oversize counts as the maximum dimension
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0)
            res = DIM_W'(1);
        else if (v > CFG_W'(MAX_DIM))
            res = DIM_W'(MAX_DIM);
        else
            res = DIM_W'(v);
        return res;
    endfunction

    // One restoring step against the divisor 2w, quotient bit b
    function automatic div_t div_step(input div_t s, input int b);
        div_t             res;
        logic [NUM_W-1:0] trial;
        res   = s;
        trial = NUM_W'(s.w) << (b + 1);
        if (s.rem >= trial) begin
            res.rem = s.rem - trial;
            res.quo = s.quo | (QUO_W'(1) << b);
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/banding_test_pattern_pixel_unit.sv -----
// ----------------------------------------------------------------------------
// banding_test_pattern_pixel_unit
// Pipeline: eight register stages, which are band decode, ramp numerator,
// five radix-2 restoring divider stages (two quotient bits each) and the
// level/output register.
// Throughput: one pixel per cycle while the colour channel is not stalled,
// every stage registered; no stage loops.
// Reset: frame size returns to 1920 x 1080, all pipeline stages empty.
// ----------------------------------------------------------------------------
module banding_test_pattern_pixel_unit
(
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration write port
    input  logic                         cfg_write,
    input  logic [0:0]                   cfg_index,
    input  logic [btp_pkg::CFG_W-1:0]    cfg_data,

    // coordinate channel
    input  logic                         coord_valid,
    output logic                         coord_stall,
    input  logic [btp_pkg::PIX_W-1:0]    pixel_x,
    input  logic [btp_pkg::PIX_W-1:0]    pixel_y,

    // colour channel
    output logic                         rgb_valid,
    input  logic                         rgb_stall,
    output logic [btp_pkg::CHAN_W-1:0]   red,
    output logic [btp_pkg::CHAN_W-1:0]   green,
    output logic [btp_pkg::CHAN_W-1:0]   blue
);

    // Stage map: 0 = band decode, 1 = ramp numerator, 2..6 = divider,
    // 7 = level and output register.
    localparam int DIV_STAGES = btp_pkg::DIV_STAGES;
    localparam int NUM_STAGES = DIV_STAGES + 3;
    localparam int IDX_DIV0   = 2;
    localparam int IDX_OUT    = NUM_STAGES - 1;
    localparam int DIM_W      = btp_pkg::DIM_W;
    localparam int TY_W       = btp_pkg::TY_W;
    localparam int TX_W       = btp_pkg::TX_W;
    localparam int ROW_W      = btp_pkg::ROW_W;
    localparam int COL_W      = btp_pkg::COL_W;
    localparam int NUM_W      = btp_pkg::NUM_W;
    localparam int QUO_W      = btp_pkg::QUO_W;
    localparam int LVL_W      = btp_pkg::LVL_W;
    localparam int CHAN_W     = btp_pkg::CHAN_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [btp_pkg::CFG_W-1:0] frame_width_reg,  frame_width_next;
    logic [btp_pkg::CFG_W-1:0] frame_height_reg, frame_height_next;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_write)
        begin
            unique case (btp_pkg::cfg_reg_t'(cfg_index))
                btp_pkg::REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                btp_pkg::REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 13'd1920;
            frame_height_reg <= 13'd1080;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage takes new data when it is empty or when the
    // stage after it is moving. Bubbles collapse, so a stalled output
    // still lets the front of the pipe fill up.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] stage_valid_reg, stage_valid_next;
    logic [NUM_STAGES-1:0] stage_open;

    always_comb
    begin
        stage_open[IDX_OUT] = !stage_valid_reg[IDX_OUT] || !rgb_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
            stage_open[i] = !stage_valid_reg[i] || stage_open[i+1];

        stage_valid_next = stage_valid_reg;
        if (stage_open[0])
            stage_valid_next[0] = coord_valid;
        for (int i = 1; i < NUM_STAGES; i++)
            if (stage_open[i])
                stage_valid_next[i] = stage_valid_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= '0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    assign coord_stall = !stage_open[0];
    assign rgb_valid   = stage_valid_reg[IDX_OUT];

    // ------------------------------------------------------------------
    // Stage 0: row and column band decode. The sample is at the pixel
    // centre, so work in units of half a pixel scaled by band count:
    // row = #{j : 6y+3 >= j*H}, col = #{j : 4x+2 >= j*W}.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] w_clamped, h_clamped;
    logic [TY_W-1:0]  ty_next;
    logic [TX_W-1:0]  tx_next;
    logic [TY_W-1:0]  h_mul [1:5];
    logic [TX_W-1:0]  w_mul [1:3];
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_next;

    logic [TY_W-1:0]  a_ty_reg;
    logic [TX_W-1:0]  a_tx_reg;
    logic [DIM_W-1:0] a_w_reg, a_h_reg;
    logic [ROW_W-1:0] a_row_reg;
    logic [COL_W-1:0] a_col_reg;

    always_comb
    begin
        w_clamped = btp_pkg::clamp_dim(frame_width_reg);
        h_clamped = btp_pkg::clamp_dim(frame_height_reg);

        ty_next = TY_W'({pixel_y, 2'b00}) + TY_W'({pixel_y, 1'b0}) + TY_W'(3);
        tx_next = TX_W'({pixel_x, 2'b10});

        h_mul[1] = TY_W'(h_clamped);
        h_mul[2] = TY_W'(h_clamped) << 1;
        h_mul[3] = (TY_W'(h_clamped) << 1) + TY_W'(h_clamped);
        h_mul[4] = TY_W'(h_clamped) << 2;
        h_mul[5] = (TY_W'(h_clamped) << 2) + TY_W'(h_clamped);
        w_mul[1] = TX_W'(w_clamped);
        w_mul[2] = TX_W'(w_clamped) << 1;
        w_mul[3] = (TX_W'(w_clamped) << 1) + TX_W'(w_clamped);

        // thresholds rise with j, so counting hits gives the band and
        // saturates at the top row / right column
        row_next = '0;
        for (int j = 1; j <= 5; j++)
            row_next = row_next + ROW_W'(ty_next >= h_mul[j]);
        col_next = '0;
        for (int j = 1; j <= 3; j++)
            col_next = col_next + COL_W'(tx_next >= w_mul[j]);
    end

    always_ff @(posedge clk)
    begin
        if (stage_open[0])
        begin
            a_ty_reg  <= ty_next;
            a_tx_reg  <= tx_next;
            a_w_reg   <= w_clamped;
            a_h_reg   <= h_clamped;
            a_row_reg <= row_next;
            a_col_reg <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: separator lines and the ramp numerator.
    // d = 4x+2 - col*W is the offset into the column; the ramp step is
    // k = (S*2d + W) div 2W with S = 8 << row, so the numerator is
    // (d << (row+4)) + W against the divisor 2W.
    // ------------------------------------------------------------------
    logic [TY_W-1:0]  row_base;
    logic [TX_W-1:0]  col_base;
    logic [TX_W-1:0]  col_offset;
    logic             dark_next;
    logic [NUM_W-1:0] num_next;

    logic [NUM_W-1:0] b_num_reg;
    logic [DIM_W-1:0] b_w_reg;
    logic [ROW_W-1:0] b_row_reg;
    logic [COL_W-1:0] b_col_reg;
    logic             b_dark_reg;

    always_comb
    begin
        case (a_row_reg)
            3'd0:    row_base = '0;
            3'd1:    row_base = TY_W'(a_h_reg);
            3'd2:    row_base = TY_W'(a_h_reg) << 1;
            3'd3:    row_base = (TY_W'(a_h_reg) << 1) + TY_W'(a_h_reg);
            3'd4:    row_base = TY_W'(a_h_reg) << 2;
            default: row_base = (TY_W'(a_h_reg) << 2) + TY_W'(a_h_reg);
        endcase
        case (a_col_reg)
            2'd0:    col_base = '0;
            2'd1:    col_base = TX_W'(a_w_reg);
            2'd2:    col_base = TX_W'(a_w_reg) << 1;
            default: col_base = (TX_W'(a_w_reg) << 1) + TX_W'(a_w_reg);
        endcase

        col_offset = a_tx_reg - col_base;

        // a line one pixel thick sits at the bottom of every row above the
        // first and at the left of every column after the first
        dark_next = ((a_row_reg != '0) && (a_ty_reg < row_base + TY_W'(6)))
                 || ((a_col_reg != '0) && (a_tx_reg < col_base + TX_W'(4)));

        num_next = (NUM_W'(col_offset) << ({1'b0, a_row_reg} + 4'd4))
                 + NUM_W'(a_w_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_open[1])
        begin
            b_num_reg  <= num_next;
            b_w_reg    <= a_w_reg;
            b_row_reg  <= a_row_reg;
            b_col_reg  <= a_col_reg;
            b_dark_reg <= dark_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2..6: restoring divider, two quotient bits per stage.
    // Quotients of 1024 and up are only flagged: any k >= S already
    // saturates the 8-bit level, and S never exceeds 256.
    // ------------------------------------------------------------------
    btp_pkg::div_t div_head;
    btp_pkg::div_t div_reg  [DIV_STAGES];
    btp_pkg::div_t div_next [DIV_STAGES];

    always_comb
    begin
        div_head.rem  = b_num_reg;
        div_head.quo  = '0;
        div_head.w    = b_w_reg;
        div_head.row  = b_row_reg;
        div_head.col  = b_col_reg;
        div_head.dark = b_dark_reg;
        div_head.sat  = b_num_reg >= (NUM_W'(b_w_reg) << (QUO_W + 1));
    end

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        if (j == 0)
        begin : g_first
            always_comb
                div_next[j] = btp_pkg::div_step(
                    btp_pkg::div_step(div_head, QUO_W - 1 - 2*j), QUO_W - 2 - 2*j);
        end
        else
        begin : g_rest
            always_comb
                div_next[j] = btp_pkg::div_step(
                    btp_pkg::div_step(div_reg[j-1], QUO_W - 1 - 2*j), QUO_W - 2 - 2*j);
        end

        always_ff @(posedge clk)
        begin
            if (stage_open[IDX_DIV0 + j])
                div_reg[j] <= div_next[j];
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: level = (510k + S) div 2S, saturated, then steered to the
    // column's channels. Separator lines override the colour.
    // ------------------------------------------------------------------
    btp_pkg::div_t     div_last;
    logic [LVL_W-1:0]  lvl_num;
    logic [LVL_W-1:0]  lvl_shifted;
    logic [CHAN_W-1:0] level;
    logic [CHAN_W-1:0] red_next, green_next, blue_next;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        div_last    = div_reg[DIV_STAGES-1];
        lvl_num     = (LVL_W'(div_last.quo) << 9) - (LVL_W'(div_last.quo) << 1)
                    + (LVL_W'(8) << div_last.row);
        lvl_shifted = lvl_num >> ({1'b0, div_last.row} + 4'd4);

        if (div_last.sat || (lvl_shifted > LVL_W'(btp_pkg::LEVEL_MAX)))
            level = btp_pkg::LEVEL_MAX;
        else
            level = lvl_shifted[CHAN_W-1:0];

        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        case (div_last.col)
            btp_pkg::COL_GRAY:
            begin
                red_next   = level;
                green_next = level;
                blue_next  = level;
            end
            btp_pkg::COL_RED:   red_next   = level;
            btp_pkg::COL_GREEN: green_next = level;
            default:            blue_next  = level;
        endcase

        if (div_last.dark)
        begin
            red_next   = btp_pkg::DARK_LEVEL;
            green_next = btp_pkg::DARK_LEVEL;
            blue_next  = btp_pkg::DARK_LEVEL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_open[IDX_OUT])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // back-pressure only reaches the input once every stage holds a pixel
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        coord_stall |-> (&stage_valid_reg))
        else $error("coordinate stalled with an empty pipeline stage");

    // an accepted coordinate always lands in the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (coord_valid && !coord_stall) |=> stage_valid_reg[0])
        else $error("accepted coordinate lost at pipeline entry");

    // divider leaves a remainder below the divisor 2W
    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg[IDX_OUT-1] && !div_reg[DIV_STAGES-1].sat)
            |-> (div_reg[DIV_STAGES-1].rem < (NUM_W'(div_reg[DIV_STAGES-1].w) << 1)))
        else $error("ramp divider remainder not reduced");

endmodule

// ----- verif/banding_colour_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banding_colour_checker
// Watches the coordinate, colour and register ports of the banding pattern
// unit, works out the colour of every accepted coordinate and compares it,
// channel by channel and in order, with the colour the unit returns.
// ----------------------------------------------------------------------------
module banding_colour_checker
    import btp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              coord_valid,
    input  logic              coord_stall,
    input  logic [PIX_W-1:0]  pixel_x,
    input  logic [PIX_W-1:0]  pixel_y,
    input  logic              rgb_valid,
    input  logic              rgb_stall,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    output int unsigned       fail_count,
    output int unsigned       colours_pending,
    output int unsigned       colours_checked,
    output int unsigned       separators_checked,
    output int unsigned       saturated_checked
);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              separator;
        logic              saturated;
    } colour_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    colour_t          colours_due[$];

    // zero reads as one pixel, anything past the maximum as the maximum
    function automatic longint unsigned frame_extent(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    function automatic colour_t banding_colour(input logic [PIX_W-1:0] px,
                                               input logic [PIX_W-1:0] py,
                                               input logic [CFG_W-1:0] w_reg,
                                               input logic [CFG_W-1:0] h_reg);
        longint unsigned w, h, ty, tx, row, col, ramp, steps, quant, lvl;
        colour_t         c;
        w  = frame_extent(w_reg);
        h  = frame_extent(h_reg);
        ty = 6 * longint'(py) + 3;
        tx = 4 * longint'(px) + 2;
        row = ty / h;
        if (row > 5)
            row = 5;
        col = tx / w;
        if (col > 3)
            col = 3;
        // centre of the pixel measured from the column's left edge, in 1/8 px
        ramp  = 8 * longint'(px) + 4 - 2 * w * col;
        steps = 64'd8 << row;
        quant = (steps * ramp + w) / (2 * w);
        lvl   = (510 * quant + steps) / (2 * steps);
        c = '0;
        c.saturated = (lvl > 255);
        if (c.saturated)
            lvl = 255;
        case (col[COL_W-1:0])
            COL_GRAY:
            begin
                c.red   = lvl[CHAN_W-1:0];
                c.green = lvl[CHAN_W-1:0];
                c.blue  = lvl[CHAN_W-1:0];
            end
            COL_RED:   c.red   = lvl[CHAN_W-1:0];
            COL_GREEN: c.green = lvl[CHAN_W-1:0];
            default:   c.blue  = lvl[CHAN_W-1:0];
        endcase
        c.separator = (row > 0 && ty < row * h + 6) || (col > 0 && tx < col * w + 4);
        if (c.separator)
        begin
            c.red   = DARK_LEVEL;
            c.green = DARK_LEVEL;
            c.blue  = DARK_LEVEL;
        end
        return c;
    endfunction

    task automatic compare_channel(input string name, input logic [CHAN_W-1:0] want,
                                   input logic [CHAN_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        colour_t want;
        if (!rst_n)
        begin
            width_reg          = CFG_W'(1920);
            height_reg         = CFG_W'(1080);
            fail_count         = 0;
            colours_checked    = 0;
            separators_checked = 0;
            saturated_checked  = 0;
            colours_due.delete();
        end
        else
        begin
            // a coordinate taken at the same edge as a write sees the old size
            if (coord_valid && !coord_stall)
                colours_due.push_back(banding_colour(pixel_x, pixel_y, width_reg, height_reg));
            if (cfg_write)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (rgb_valid && !rgb_stall)
            begin
                if (colours_due.size() == 0)
                begin
                    $error("colour transaction with no coordinate outstanding");
                    fail_count++;
                end
                else
                begin
                    want = colours_due.pop_front();
                    compare_channel("red", want.red, red);
                    compare_channel("green", want.green, green);
                    compare_channel("blue", want.blue, blue);
                    colours_checked++;
                    if (want.separator)
                        separators_checked++;
                    if (want.saturated)
                        saturated_checked++;
                end
            end
        end
        colours_pending = colours_due.size();
    end

endmodule

// ----- verif/banding_test_pattern_pixel_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banding_test_pattern_pixel_unit_tb
// Drives coordinates into the banding pattern unit under a series of frame
// sizes, from the smallest to past the largest, and lets the colour checker
// judge every returned pixel. Both sides idle at random in bursts.
// ----------------------------------------------------------------------------
module banding_test_pattern_pixel_unit_tb;
    import btp_pkg::*;

    localparam int RUN_LIMIT     = 100000; // watchdog limit, well above the longest legal run
    localparam int SETTLE_CYCLES = 16;     // settle time after the last colour returns
    localparam int PHASE_ITEMS   = 50;
    localparam int NUM_FRAMES    = 8;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [0:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              coord_valid;
    logic              coord_stall;
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
    logic              rgb_valid;
    logic              rgb_stall;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    int unsigned fail_count;
    int unsigned colours_pending;
    int unsigned colours_checked;
    int unsigned separators_checked;
    int unsigned saturated_checked;

    int unsigned cycle_count;
    int unsigned frames_tried;

    // source side idling: bursts with gaps, bursts without
    int src_burst;
    bit src_quiet;
    // sink side idling
    int hold_left;
    int sink_burst;
    bit sink_quiet;

    banding_test_pattern_pixel_unit u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .coord_valid (coord_valid),
        .coord_stall (coord_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .rgb_valid   (rgb_valid),
        .rgb_stall   (rgb_stall),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    banding_colour_checker u_checker
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .coord_valid        (coord_valid),
        .coord_stall        (coord_stall),
        .pixel_x            (pixel_x),
        .pixel_y            (pixel_y),
        .rgb_valid          (rgb_valid),
        .rgb_stall          (rgb_stall),
        .red                (red),
        .green              (green),
        .blue               (blue),
        .fail_count         (fail_count),
        .colours_pending    (colours_pending),
        .colours_checked    (colours_checked),
        .separators_checked (separators_checked),
        .saturated_checked  (saturated_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        wait (cycle_count >= RUN_LIMIT);
        $display("banding_test_pattern_pixel_unit verification failed");
        $finish;
    end

    // colour sink: after each transaction outside a quiet burst, hold off at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_stall  <= 1'b0;
            hold_left  = 0;
            sink_burst = 0;
            sink_quiet = 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            rgb_stall <= (hold_left != 0);
        end
        else if (rgb_valid && !rgb_stall)
        begin
            if (sink_burst == 0)
            begin
                sink_burst = $urandom_range(8, 40);
                sink_quiet = ($urandom_range(0, 2) == 0);
            end
            sink_burst--;
            hold_left = sink_quiet ? 0 : $urandom_range(0, 6);
            rgb_stall <= (hold_left != 0);
        end
    end

    // One coordinate transaction. Returns at the edge that accepted it, with
    // valid still high so back-to-back items need no drop.
    task automatic send_coord(input int x, input int y);
        int gap;
        if (src_burst == 0)
        begin
            src_burst = $urandom_range(8, 40);
            src_quiet = ($urandom_range(0, 2) == 0);
        end
        src_burst--;
        gap = src_quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            coord_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coord_valid <= 1'b1;
        pixel_x     <= PIX_W'(x);
        pixel_y     <= PIX_W'(y);
        @(posedge clk);
        while (coord_stall)
            @(posedge clk);
    endtask

    // Block goes quiet: nothing owed, then let the pipeline empty out.
    task automatic drain_colours();
        coord_valid <= 1'b0;
        do
            @(negedge clk);
        while (colours_pending != 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        drain_colours();
        cfg_write <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(posedge clk);
        cfg_write <= 1'b0;
        frames_tried++;
    endtask

    initial
    begin
        int frame_w[NUM_FRAMES];
        int frame_h[NUM_FRAMES];
        int we, he, pick, band, x, y;

        // frame sizes per phase: default, zero (reads as 1), smallest legal,
        // largest, oversized (clamps), one by max, a common size, then random
        frame_w = '{1920, 0, 8, 4096, 8191, 1, 640, 0};
        frame_h = '{1080, 0, 6, 4096, 5000, 4096, 480, 0};

        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_FRAME_WIDTH;
        cfg_data     = '0;
        coord_valid  = 1'b0;
        pixel_x      = '0;
        pixel_y      = '0;
        src_burst    = 0;
        src_quiet    = 1'b0;
        frames_tried = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset size 1920 x 1080.
        // Corners, all-zero and all-one coordinates.
        send_coord(0, 0);
        send_coord(4095, 4095);
        send_coord(4095, 0);
        send_coord(0, 4095);
        // last pixel inside the frame, then just outside it
        send_coord(1919, 1079);
        send_coord(1920, 1080);
        // pixels either side of the first column and row separators
        send_coord(479, 179);
        send_coord(480, 180);
        send_coord(481, 181);
        send_coord(960, 540);
        send_coord(1440, 900);
        // one pixel in every row, walking across the four columns
        for (int r = 0; r < 6; r++)
            send_coord(240 + 480 * (r % 4) + 37 * r, 90 + 180 * r);
        // ramp start and end within the gray column of the top row
        send_coord(1, 1000);
        send_coord(478, 1000);

        // Random part, one phase per frame size.
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            if (f == NUM_FRAMES - 1)
            begin
                frame_w[f] = $urandom_range(8, 4096);
                frame_h[f] = $urandom_range(6, 4096);
            end
            set_frame(frame_w[f], frame_h[f]);
            we = (frame_w[f] == 0) ? 1 : (frame_w[f] > MAX_DIM ? MAX_DIM : frame_w[f]);
            he = (frame_h[f] == 0) ? 1 : (frame_h[f] > MAX_DIM ? MAX_DIM : frame_h[f]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                begin
                    // anywhere in the coordinate space, mostly outside small frames
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                else if (pick < 45)
                begin
                    // hug a column or row boundary
                    band = $urandom_range(1, 3);
                    x = (band * we) / 4 + $urandom_range(0, 3) - 2;
                    band = $urandom_range(1, 5);
                    y = (pick < 33) ? $urandom_range(0, he - 1)
                                    : (band * he) / 6 + $urandom_range(0, 3) - 2;
                end
                else
                begin
                    x = $urandom_range(0, we - 1);
                    y = $urandom_range(0, he - 1);
                end
                x = (x < 0) ? 0 : (x > 4095 ? 4095 : x);
                y = (y < 0) ? 0 : (y > 4095 ? 4095 : y);
                send_coord(x, y);
            end
        end

        drain_colours();

        $display("%0d pixels checked over %0d frame sizes after the reset size",
                 colours_checked, frames_tried);
        $display("%0d fell on separator lines, %0d had the ramp level clipped at full scale",
                 separators_checked, saturated_checked);
        if (fail_count == 0 && colours_pending == 0)
            $display("banding_test_pattern_pixel_unit verification clean");
        else
            $display("banding_test_pattern_pixel_unit verification failed");
        $finish;
    end

endmodule
